// ===== sv/gslqr_pkg.sv =====
// Shared constants, word and command types, and saturation helper for the gain-scheduled LQR block.
package gslqr_pkg;

	localparam int MAX_TERMS  = 8;
	localparam int GAIN_COUNT = 12;
	localparam int ROW_LEN    = 6;

	localparam int LEN_W   = 18;
	localparam int GIDX_W  = 4;
	localparam int TIDX_IN = 3;
	localparam int COL_W   = 3;
	localparam int CNT_W   = $clog2(MAX_TERMS + 1);
	localparam int TIDX_W  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int MEM_DEPTH = GAIN_COUNT * MAX_TERMS;
	localparam int ADDR_W  = $clog2(MEM_DEPTH);

	localparam int PADDR_W = 3;
	localparam logic [PADDR_W-1:0] ADDR_TERM_COUNT = 3'd0;

	localparam int SAT_W = 50;
	localparam logic signed [SAT_W-1:0] Q_MAX = 50'sd2147483647;
	localparam logic signed [SAT_W-1:0] Q_MIN = -50'sd2147483648;

	typedef enum logic [1:0] {
		KIND_COEF   = 2'd0,
		KIND_SCHED  = 2'd1,
		KIND_TORQUE = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t                 kind;
		logic [GIDX_W-1:0]     gain_index;
		logic [TIDX_IN-1:0]    term_index;
		logic signed [31:0]    coefficient;
		logic [LEN_W-1:0]      leg_length;
		logic signed [31:0]    pitch;
		logic signed [31:0]    pitch_rate;
		logic signed [31:0]    position;
		logic signed [31:0]    speed;
		logic signed [31:0]    leg_angle;
		logic signed [31:0]    leg_angle_rate;
	} item_t;

	typedef struct packed {
		logic signed [31:0] wheel_torque;
		logic signed [31:0] hip_torque;
		logic               saturated;
	} result_t;

	typedef struct packed {
		logic              take;
		logic [GIDX_W-1:0] gsel;
		logic [COL_W-1:0]  col;
		logic [TIDX_W-1:0] term;
		logic              rd_en;
		logic              acc_load;
		logic              mul_horner;
		logic              acc_step;
		logic              gain_wr;
		logic              gain_clr;
		logic              mul_torque;
		logic              sum_step;
		logic              row_done;
		logic              row;
		logic              out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_sts_t;

	typedef struct packed {
		logic               clip;
		logic signed [31:0] value;
	} sat_t;

	function automatic sat_t sat32(input logic signed [SAT_W-1:0] v);
		sat_t r;
		if (v > Q_MAX) begin
			r.clip  = 1'b1;
			r.value = 32'sh7FFF_FFFF;
		end else if (v < Q_MIN) begin
			r.clip  = 1'b1;
			r.value = 32'sh8000_0000;
		end else begin
			r.clip  = 1'b0;
			r.value = 32'(v);
		end
		return r;
	endfunction

endpackage

// ===== sv/gain_scheduled_lqr_controller.sv =====
// Top level of the gain-scheduled LQR state-feedback controller.
//
//   channel   direction  handshake                    word
//   item      in         item_valid / item_stall      item_t (coefficient, length or state)
//   result    out        result_valid / result_stall  result_t (two torques, clip flag)
//   config    in         APB psel/penable/pwrite      term_count at byte address 0
//
// A coefficient word is taken from idle. A scheduling word evaluates the twelve gains in turn
// (n = used term count; each gain is cleared when n is zero), paced by the single shared
// multiplier and coefficient memory read port feeding each Horner step (multiply, then add).
// A torque word runs twelve multiply/accumulate pairs, two row rounds and the output load.
// Reset clears the gains and term_count; the coefficient memory holds no reset value.
// The item side stalls while a word is in work; a finished result waits in the output
// register while the next word is accepted, and blocks only the following torque result.
module gain_scheduled_lqr_controller
	import gslqr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  item_t              item,
	output logic               result_valid,
	input  logic               result_stall,
	output result_t            result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [3:0] term_count_q;
	dp_cmd_t    cmd;
	dp_sts_t    sts;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_TERM_COUNT) ? 32'(term_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_count_q <= '0;
		end else if (psel && penable && pwrite && pready && (paddr == ADDR_TERM_COUNT)) begin
			term_count_q <= pwdata[3:0];
		end
	end

	gslqr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.kind       (item.kind),
		.term_count (term_count_q),
		.sts        (sts),
		.item_stall (item_stall),
		.cmd        (cmd)
	);

	gslqr_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.result_stall (result_stall),
		.sts          (sts),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

// ===== sv/gslqr_ctrl.sv =====
// Sequencer that steps the Horner evaluation and the torque dot products on the shared datapath.
module gslqr_ctrl
	import gslqr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  kind_t                kind,
	input  logic [3:0]           term_count,
	input  dp_sts_t              sts,
	output logic                 item_stall,
	output dp_cmd_t              cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_G_START,
		ST_G_LOAD,
		ST_G_MUL,
		ST_G_ADD,
		ST_G_STORE,
		ST_T_MUL,
		ST_T_ACC,
		ST_T_ROW,
		ST_T_OUT
	} state_t;

	state_t            state_q;
	logic [GIDX_W-1:0] g_q;
	logic [COL_W-1:0]  col_q;
	logic [TIDX_W-1:0] t_q;
	logic              row_q;
	logic [CNT_W-1:0]  n_terms;

	// Term counts beyond the store depth use every stored term.
	assign n_terms = (32'(term_count) > MAX_TERMS) ? CNT_W'(MAX_TERMS) : CNT_W'(term_count);

	assign item_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.gsel       = g_q;
		cmd.col        = col_q;
		cmd.row        = row_q;
		cmd.term       = TIDX_W'(t_q - 1'b1);
		unique case (state_q)
			ST_IDLE: begin
				cmd.take = item_valid;
			end
			ST_G_START: begin
				if (n_terms == '0) begin
					cmd.gain_clr = 1'b1;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.term  = TIDX_W'(n_terms - 1'b1);
				end
			end
			ST_G_LOAD: begin
				cmd.acc_load = 1'b1;
				cmd.rd_en    = (t_q != '0);
			end
			ST_G_MUL: begin
				cmd.mul_horner = 1'b1;
			end
			ST_G_ADD: begin
				cmd.acc_step = 1'b1;
				cmd.rd_en    = (t_q != '0);
			end
			ST_G_STORE: begin
				cmd.gain_wr = 1'b1;
			end
			ST_T_MUL: begin
				cmd.mul_torque = 1'b1;
			end
			ST_T_ACC: begin
				cmd.sum_step = 1'b1;
			end
			ST_T_ROW: begin
				cmd.row_done = 1'b1;
			end
			ST_T_OUT: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			g_q     <= '0;
			col_q   <= '0;
			t_q     <= '0;
			row_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					g_q   <= '0;
					col_q <= '0;
					row_q <= 1'b0;
					if (item_valid) begin
						priority if (kind == KIND_SCHED) begin
							state_q <= ST_G_START;
						end else if (kind == KIND_TORQUE) begin
							state_q <= ST_T_MUL;
						end
					end
				end
				ST_G_START: begin
					if (n_terms == '0) begin
						if (32'(g_q) == GAIN_COUNT - 1) begin
							state_q <= ST_IDLE;
						end else begin
							g_q <= g_q + 1'b1;
						end
					end else begin
						t_q     <= TIDX_W'(n_terms - 1'b1);
						state_q <= ST_G_LOAD;
					end
				end
				ST_G_LOAD, ST_G_ADD: begin
					if (t_q == '0) begin
						state_q <= ST_G_STORE;
					end else begin
						t_q     <= t_q - 1'b1;
						state_q <= ST_G_MUL;
					end
				end
				ST_G_MUL: begin
					state_q <= ST_G_ADD;
				end
				ST_G_STORE: begin
					if (32'(g_q) == GAIN_COUNT - 1) begin
						state_q <= ST_IDLE;
					end else begin
						g_q     <= g_q + 1'b1;
						state_q <= ST_G_START;
					end
				end
				ST_T_MUL: begin
					state_q <= ST_T_ACC;
				end
				ST_T_ACC: begin
					if (32'(col_q) == ROW_LEN - 1) begin
						state_q <= ST_T_ROW;
					end else begin
						col_q   <= col_q + 1'b1;
						g_q     <= g_q + 1'b1;
						state_q <= ST_T_MUL;
					end
				end
				ST_T_ROW: begin
					if (row_q) begin
						state_q <= ST_T_OUT;
					end else begin
						row_q   <= 1'b1;
						col_q   <= '0;
						g_q     <= g_q + 1'b1;
						state_q <= ST_T_MUL;
					end
				end
				ST_T_OUT: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/gslqr_dp.sv =====
// Datapath: coefficient memory, gain registers, shared multiplier, Horner and dot-product accumulators.
module gslqr_dp
	import gslqr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  dp_cmd_t cmd,
	input  logic    result_stall,
	output dp_sts_t sts,
	output logic    result_valid,
	output result_t result
);

	logic [31:0]         mem [MEM_DEPTH];
	logic [31:0]         rd_q;
	item_t               in_q;
	logic signed [31:0]  gain_q [GAIN_COUNT];
	logic signed [31:0]  acc_q;
	logic signed [63:0]  prod_q;
	logic signed [65:0]  sum_q;
	logic signed [31:0]  wheel_q;
	logic signed [31:0]  hip_q;
	logic                clip_q;
	result_t             out_q;
	logic                out_valid_q;

	logic                coef_we;
	logic [ADDR_W-1:0]   wr_addr;
	logic [ADDR_W-1:0]   rd_addr;
	logic signed [31:0]  mul_a;
	logic signed [31:0]  mul_b;
	logic signed [31:0]  x_sel;
	logic signed [63:0]  rnd;
	logic signed [SAT_W-1:0] hsum;
	sat_t                h_sat;
	sat_t                t_sat;

	// Out-of-range coefficient writes are dropped.
	assign coef_we = cmd.take && (item.kind == KIND_COEF) &&
		(32'(item.gain_index) < GAIN_COUNT) && (32'(item.term_index) < MAX_TERMS);
	assign wr_addr = ADDR_W'(ADDR_W'(item.gain_index) * ADDR_W'(MAX_TERMS)) +
		ADDR_W'(item.term_index);
	assign rd_addr = ADDR_W'(ADDR_W'(cmd.gsel) * ADDR_W'(MAX_TERMS)) + ADDR_W'(cmd.term);

	always_ff @(posedge clk) begin
		if (coef_we) begin
			mem[wr_addr] <= item.coefficient;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_comb begin
		unique case (cmd.col)
			3'd0:    x_sel = in_q.pitch;
			3'd1:    x_sel = in_q.pitch_rate;
			3'd2:    x_sel = in_q.position;
			3'd3:    x_sel = in_q.speed;
			3'd4:    x_sel = in_q.leg_angle;
			default: x_sel = in_q.leg_angle_rate;
		endcase
	end

	assign mul_a = cmd.mul_horner ? acc_q : gain_q[cmd.gsel];
	assign mul_b = cmd.mul_horner ? $signed(32'(in_q.leg_length)) : x_sel;

	// One Horner step: round the product back to Q16.16, add the next coefficient.
	assign rnd   = prod_q + 64'sd32768;
	assign hsum  = SAT_W'(rnd >>> 16) + SAT_W'($signed(rd_q));
	assign h_sat = sat32(hsum);

	// The sum is kept negated with the rounding half already added.
	assign t_sat = sat32(SAT_W'(sum_q >>> 16));

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			in_q <= item;
		end
		if (cmd.mul_horner || cmd.mul_torque) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.acc_load) begin
			acc_q <= $signed(rd_q);
		end else if (cmd.acc_step) begin
			acc_q <= h_sat.value;
		end
		if (cmd.take || cmd.row_done) begin
			sum_q <= 66'sd32768;
		end else if (cmd.sum_step) begin
			sum_q <= sum_q - 66'(prod_q);
		end
		if (cmd.row_done) begin
			if (cmd.row) begin
				hip_q <= t_sat.value;
			end else begin
				wheel_q <= t_sat.value;
			end
		end
		if (cmd.out_load) begin
			out_q.wheel_torque <= wheel_q;
			out_q.hip_torque   <= hip_q;
			out_q.saturated    <= clip_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < GAIN_COUNT; i++) begin
				gain_q[i] <= '0;
			end
			clip_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.gain_wr) begin
				gain_q[cmd.gsel] <= acc_q;
			end else if (cmd.gain_clr) begin
				gain_q[cmd.gsel] <= '0;
			end
			if (cmd.take) begin
				clip_q <= 1'b0;
			end else if (cmd.row_done) begin
				clip_q <= clip_q | t_sat.clip;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.out_free  = !out_valid_q || !result_stall;
	assign result_valid  = out_valid_q;
	assign result        = out_q;

endmodule
